[hw/rtl/bcdw_pkg.sv]
// Shared types, mode codes and divide-by-constant helpers for the watch display formatter.
`timescale 1ns / 1ps
`default_nettype none

package bcdw_pkg;

  localparam int unsigned ValueW     = 16;
  localparam int unsigned CmdW       = 5;
  localparam int unsigned NibW       = 4;
  localparam int unsigned NumCols    = 4;
  localparam int unsigned ColW       = 2;
  localparam int unsigned BrightW    = 8;
  localparam int unsigned DigitsW    = NumCols * NibW;
  localparam int unsigned QueueDepth = 4;

  localparam logic [BrightW-1:0] BrightReset = 8'd240;
  localparam logic [ColW-1:0]    LastCol     = 2'd3;

  // Display modes
  localparam logic [CmdW-1:0] CmdEmpty     = 5'd0;
  localparam logic [CmdW-1:0] CmdFadein    = 5'd1;
  localparam logic [CmdW-1:0] CmdTime      = 5'd2;
  localparam logic [CmdW-1:0] CmdSetHour   = 5'd3;
  localparam logic [CmdW-1:0] CmdSetMinute = 5'd4;
  localparam logic [CmdW-1:0] CmdDebounce  = 5'd5;
  localparam logic [CmdW-1:0] CmdTimeS     = 5'd6;
  localparam logic [CmdW-1:0] CmdDate      = 5'd7;
  localparam logic [CmdW-1:0] CmdSetDay    = 5'd8;
  localparam logic [CmdW-1:0] CmdSetMonth  = 5'd9;
  localparam logic [CmdW-1:0] CmdDebDate   = 5'd10;
  localparam logic [CmdW-1:0] CmdSetYear   = 5'd11;
  localparam logic [CmdW-1:0] CmdSteps     = 5'd12;
  localparam logic [CmdW-1:0] CmdHistory   = 5'd13;
  localparam logic [CmdW-1:0] CmdUbatt     = 5'd14;
  localparam logic [CmdW-1:0] CmdError     = 5'd15;
  localparam logic [CmdW-1:0] CmdRaw       = 5'd16;

  // Reciprocals for exact floor division of any 16-bit value: q = (x * R) >> S
  localparam int unsigned     ProdW      = 33;
  localparam logic [16:0]     Recip10    = 17'd52429;
  localparam logic [16:0]     Recip100   = 17'd83887;
  localparam logic [16:0]     Recip1000  = 17'd67109;
  localparam logic [16:0]     Recip10000 = 17'd107375;

  // How the four digits are assembled from the decimal expansion
  typedef enum logic [2:0] {
    FmtFixed,
    FmtTime,
    FmtDate,
    FmtYear,
    FmtCount,
    FmtBatt,
    FmtError
  } bcdw_fmt_e;

  typedef struct packed {
    bcdw_fmt_e                      fmt;
    logic [ValueW-1:0]              x;
    logic [ValueW-1:0]              y;
    logic [NumCols-1:0]             mask;
    logic [NumCols-1:0][NibW-1:0]   fix;
  } bcdw_req_t;

  typedef struct packed {
    bcdw_fmt_e                      fmt;
    logic [NibW-1:0]                x_n;
    logic [NibW-1:0]                y_n;
    logic [NibW-1:0]                q1_n;
    logic [NibW-1:0]                q2_n;
    logic [NibW-1:0]                q3_n;
    logic [2:0]                     q4;
    logic [NibW-1:0]                qy1_n;
    logic [NumCols-1:0]             mask;
    logic [NumCols-1:0][NibW-1:0]   fix;
  } bcdw_quot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bcdw_qstat_t;

  // n - 10*q, known to lie in 0..9, so the low nibbles of n and q suffice
  function automatic logic [NibW-1:0] rem10_nib(logic [NibW-1:0] n, logic [NibW-1:0] q);
    logic [NibW-1:0] t;
    t = {q[0], 3'b000} + {q[2:0], 1'b0};
    return n - t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bcd_watch_display_formatter.sv]
// Top level of the wristwatch display formatter: front end, digit queue, column scanner.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid_i / in_stall_o): one display request per item, a mode,
//   four 16-bit values and the blink phase. An empty request is taken and dropped.
//   Output channel (out_valid_o / out_stall_i): each other request yields four
//   column items, column 0 (hour tens) to column 3, last_o marking column 3, each
//   with on time = brightness and off time = 255 - brightness.
//   Config channel (cfg_valid_i / cfg_ready_o): writes brightness; ready is always
//   high. Write it only while the block is idle.
//   Path: a request passes the classify stage, the divider stage, the queue, then
//   the scan register before its first column appears.
//   Throughput: the front takes a request every cycle until its two stages and the
//   queue are full; the sustained rate is set by the four-column scan of the back
//   end, one column per cycle while the receiver does not stall.
//   A stalled receiver freezes the current column; the front keeps absorbing
//   requests until the queue backs up, then raises in_stall_o.
//   Reset: all pipelines and the queue empty, brightness returns to 240.
module bcd_watch_display_formatter #(
  parameter int unsigned QueueDepth = bcdw_pkg::QueueDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [bcdw_pkg::CmdW-1:0]          cmd_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]        value_a_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]        value_b_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]        value_c_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]        value_d_i,
  input  wire logic                               blink_off_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bcdw_pkg::BrightW-1:0]       cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [bcdw_pkg::ColW-1:0]               column_o,
  output logic [bcdw_pkg::NibW-1:0]               digit_o,
  output logic [bcdw_pkg::BrightW-1:0]            on_time_o,
  output logic [bcdw_pkg::BrightW-1:0]            off_time_o,
  output logic                                    last_o
);

  logic [bcdw_pkg::BrightW-1:0] brightness_q;
  bcdw_pkg::bcdw_qstat_t        qstat;
  logic                         push, pop;
  logic [bcdw_pkg::DigitsW-1:0] push_data, pop_data;

  // Brightness register; always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= bcdw_pkg::BrightReset;
    end else if (cfg_valid_i) begin
      brightness_q <= cfg_data_i;
    end
  end

  // Classify and split into digits
  bcdw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_a_i   (value_a_i),
    .value_b_i   (value_b_i),
    .value_c_i   (value_c_i),
    .value_d_i   (value_d_i),
    .blink_off_i (blink_off_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple front and scanner
  bcdw_queue #(
    .Depth (QueueDepth),
    .Width (bcdw_pkg::DigitsW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .qstat_o (qstat)
  );

  // Scan columns out
  bcdw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .brightness_i (brightness_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_o     (column_o),
    .digit_o      (digit_o),
    .on_time_o    (on_time_o),
    .off_time_o   (off_time_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[hw/rtl/bcdw_front.sv]
// Front end: accept requests, classify the mode, split values into decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module bcdw_front (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [bcdw_pkg::CmdW-1:0]              cmd_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]            value_a_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]            value_b_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]            value_c_i,
  input  wire logic [bcdw_pkg::ValueW-1:0]            value_d_i,
  input  wire logic                                   blink_off_i,
  input  wire bcdw_pkg::bcdw_qstat_t                  qstat_i,
  output logic                                        push_o,
  output logic [bcdw_pkg::DigitsW-1:0]                push_data_o
);

  bcdw_pkg::bcdw_req_t  req_d, s1_q;
  bcdw_pkg::bcdw_quot_t quot_d, s2_q;
  logic s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic en1, en2, in_fire;
  logic [bcdw_pkg::ProdW-1:0] px1, px2, px3, px4, py1;
  logic [bcdw_pkg::NumCols-1:0][bcdw_pkg::NibW-1:0] dig;
  logic [bcdw_pkg::NibW-1:0] rx0, rx1, rx2, rx3, ry0;

  assign en2        = !s2_valid_q || !qstat_i.full;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;
  assign in_fire    = in_valid_i && en1;
  assign push_o     = s2_valid_q && !qstat_i.full;

  // Classify
  always_comb begin
    req_d      = '0;
    req_d.fmt  = bcdw_pkg::FmtFixed;
    req_d.x    = value_a_i;
    req_d.y    = value_b_i;
    req_d.mask = '0;
    req_d.fix  = '1;
    unique case (cmd_i)
      bcdw_pkg::CmdFadein, bcdw_pkg::CmdTime, bcdw_pkg::CmdSetHour,
      bcdw_pkg::CmdSetMinute, bcdw_pkg::CmdDebounce: begin
        // midnight reads 2400
        req_d.fmt    = (value_a_i == '0 && value_b_i == '0) ? bcdw_pkg::FmtFixed
                                                             : bcdw_pkg::FmtTime;
        req_d.fix[0] = 4'd2;
        req_d.fix[1] = 4'd4;
        req_d.fix[2] = 4'd0;
        req_d.fix[3] = 4'd0;
        req_d.mask[0] = blink_off_i &&
                        (cmd_i == bcdw_pkg::CmdSetHour || cmd_i == bcdw_pkg::CmdDebounce);
        req_d.mask[2] = blink_off_i &&
                        (cmd_i == bcdw_pkg::CmdSetMinute || cmd_i == bcdw_pkg::CmdDebounce);
      end
      bcdw_pkg::CmdTimeS: begin
        req_d.fmt = bcdw_pkg::FmtTime;
        req_d.x   = value_b_i;
        req_d.y   = value_c_i;
      end
      bcdw_pkg::CmdDate, bcdw_pkg::CmdSetDay, bcdw_pkg::CmdSetMonth,
      bcdw_pkg::CmdDebDate: begin
        req_d.fmt    = bcdw_pkg::FmtDate;
        req_d.fix[0] = 4'd3;
        req_d.fix[3] = value_b_i[3:0];
        req_d.mask[1] = blink_off_i &&
                        (cmd_i == bcdw_pkg::CmdSetDay || cmd_i == bcdw_pkg::CmdDebDate);
        req_d.mask[2] = blink_off_i &&
                        (cmd_i == bcdw_pkg::CmdSetMonth || cmd_i == bcdw_pkg::CmdDebDate);
      end
      bcdw_pkg::CmdSetYear: begin
        req_d.fmt    = bcdw_pkg::FmtYear;
        req_d.x      = value_c_i;
        req_d.fix[0] = 4'd3;
        req_d.fix[1] = blink_off_i ? 4'd9 : 4'd6;
      end
      bcdw_pkg::CmdSteps: begin
        req_d.fmt    = bcdw_pkg::FmtCount;
        req_d.x      = value_c_i;
        req_d.fix[0] = 4'd7;
      end
      bcdw_pkg::CmdHistory: begin
        req_d.fmt    = bcdw_pkg::FmtCount;
        req_d.x      = value_b_i;
        req_d.fix[0] = {1'b1, value_a_i[2:0]};
      end
      bcdw_pkg::CmdUbatt: begin
        req_d.fmt    = bcdw_pkg::FmtBatt;
        req_d.fix[0] = 4'd4;
      end
      bcdw_pkg::CmdError: begin
        req_d.fmt    = bcdw_pkg::FmtError;
        req_d.x      = value_b_i;
        req_d.fix[0] = 4'd14;
        req_d.fix[1] = value_a_i[3:0];
      end
      bcdw_pkg::CmdRaw: begin
        req_d.fix[0] = value_a_i[3:0];
        req_d.fix[1] = value_b_i[3:0];
        req_d.fix[2] = value_c_i[3:0];
        req_d.fix[3] = value_d_i[3:0];
      end
      default: begin
        req_d.fix = '1;
      end
    endcase
  end

  // Quotients by 10, 100, 1000, 10000
  always_comb begin
    px1 = bcdw_pkg::ProdW'(s1_q.x) * bcdw_pkg::ProdW'(bcdw_pkg::Recip10);
    px2 = bcdw_pkg::ProdW'(s1_q.x) * bcdw_pkg::ProdW'(bcdw_pkg::Recip100);
    px3 = bcdw_pkg::ProdW'(s1_q.x) * bcdw_pkg::ProdW'(bcdw_pkg::Recip1000);
    px4 = bcdw_pkg::ProdW'(s1_q.x) * bcdw_pkg::ProdW'(bcdw_pkg::Recip10000);
    py1 = bcdw_pkg::ProdW'(s1_q.y) * bcdw_pkg::ProdW'(bcdw_pkg::Recip10);
    quot_d       = '0;
    quot_d.fmt   = s1_q.fmt;
    quot_d.x_n   = s1_q.x[3:0];
    quot_d.y_n   = s1_q.y[3:0];
    quot_d.q1_n  = px1[22:19];
    quot_d.q2_n  = px2[26:23];
    quot_d.q3_n  = px3[29:26];
    quot_d.q4    = px4[32:30];
    quot_d.qy1_n = py1[22:19];
    quot_d.mask  = s1_q.mask;
    quot_d.fix   = s1_q.fix;
  end

  // Remainders and digit assembly
  always_comb begin
    rx0 = bcdw_pkg::rem10_nib(s2_q.x_n, s2_q.q1_n);
    rx1 = bcdw_pkg::rem10_nib(s2_q.q1_n, s2_q.q2_n);
    rx2 = bcdw_pkg::rem10_nib(s2_q.q2_n, s2_q.q3_n);
    rx3 = bcdw_pkg::rem10_nib(s2_q.q3_n, {1'b0, s2_q.q4});
    ry0 = bcdw_pkg::rem10_nib(s2_q.y_n, s2_q.qy1_n);
    dig = s2_q.fix;
    unique case (s2_q.fmt)
      bcdw_pkg::FmtFixed: dig = s2_q.fix;
      bcdw_pkg::FmtTime: begin
        dig[0] = s2_q.q1_n;
        dig[1] = rx0;
        dig[2] = s2_q.qy1_n;
        dig[3] = ry0;
      end
      bcdw_pkg::FmtDate: begin
        dig[1] = s2_q.q1_n;
        dig[2] = rx0;
      end
      bcdw_pkg::FmtYear: begin
        dig[2] = s2_q.q1_n;
        dig[3] = rx0;
      end
      bcdw_pkg::FmtCount: begin
        dig[1] = {1'b0, s2_q.q4};
        dig[2] = rx3;
        dig[3] = rx2;
      end
      bcdw_pkg::FmtBatt: begin
        dig[1] = s2_q.q3_n;
        dig[2] = rx2;
        dig[3] = rx1;
      end
      bcdw_pkg::FmtError: begin
        dig[2] = rx1;
        dig[3] = rx0;
      end
      default: dig = s2_q.fix;
    endcase
    for (int k = 0; k < bcdw_pkg::NumCols; k++) begin
      dig[k][3] = dig[k][3] | s2_q.mask[k];
    end
  end

  assign push_data_o = dig;

  assign s1_valid_d = en1 ? (in_fire && cmd_i != bcdw_pkg::CmdEmpty) : s1_valid_q;
  assign s2_valid_d = en2 ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= req_d;
    end
    if (en2) begin
      s2_q <= quot_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bcdw_queue.sv]
// Small FIFO of formatted digit words between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module bcdw_queue #(
  parameter int unsigned Depth = bcdw_pkg::QueueDepth,
  parameter int unsigned Width = bcdw_pkg::DigitsW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [Width-1:0]  data_i,
  input  wire logic              pop_i,
  output logic [Width-1:0]       data_o,
  output bcdw_pkg::bcdw_qstat_t  qstat_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign qstat_o.full  = (count_q == CntW'(Depth));
  assign qstat_o.empty = (count_q == '0);
  assign data_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty) else $error("pop from empty queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !qstat_o.empty) else $error("queue empty after push");

endmodule

`default_nettype wire

[hw/rtl/bcdw_back.sv]
// Back end: scan the four columns of each queued digit word onto the result channel.
`timescale 1ns / 1ps
`default_nettype none

module bcdw_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bcdw_pkg::bcdw_qstat_t              qstat_i,
  output logic                                    pop_o,
  input  wire logic [bcdw_pkg::DigitsW-1:0]       pop_data_i,
  input  wire logic [bcdw_pkg::BrightW-1:0]       brightness_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [bcdw_pkg::ColW-1:0]               column_o,
  output logic [bcdw_pkg::NibW-1:0]               digit_o,
  output logic [bcdw_pkg::BrightW-1:0]            on_time_o,
  output logic [bcdw_pkg::BrightW-1:0]            off_time_o,
  output logic                                    last_o
);

  logic                                             valid_q;
  logic [bcdw_pkg::ColW-1:0]                        col_q;
  logic [bcdw_pkg::NumCols-1:0][bcdw_pkg::NibW-1:0] digits_q;
  logic fire, done;

  assign fire  = valid_q && !out_stall_i;
  assign done  = !valid_q || (fire && col_q == bcdw_pkg::LastCol);
  assign pop_o = done && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
    end else if (done) begin
      valid_q <= !qstat_i.empty;
      col_q   <= '0;
    end else if (fire) begin
      col_q <= col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digits_q <= pop_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign column_o    = col_q;
  assign digit_o     = digits_q[col_q];
  assign on_time_o   = brightness_i;
  assign off_time_o  = ~brightness_i;
  assign last_o      = (col_q == bcdw_pkg::LastCol);

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_o && qstat_i.empty) |=> !out_valid_o)
    else $error("result valid with nothing queued");
  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> (out_valid_o && column_o == $past(column_o) + 1'b1))
    else $error("column scan broken");

endmodule

`default_nettype wire
